@@ design/pts_pkg.sv @@
// Package for the priority task scheduler: opcodes, status codes, entry states,
// controller command/status structs. No dependencies.
package pts_pkg;
    localparam int MaxEntriesDef = 16;

    localparam logic [3:0] OP_INIT    = 4'd0;
    localparam logic [3:0] OP_CREATE  = 4'd1;
    localparam logic [3:0] OP_DELETE  = 4'd2;
    localparam logic [3:0] OP_SUSPEND = 4'd3;
    localparam logic [3:0] OP_RESUME  = 4'd4;
    localparam logic [3:0] OP_SETPER  = 4'd5;
    localparam logic [3:0] OP_SETPRI  = 4'd6;
    localparam logic [3:0] OP_DELAY   = 4'd7;
    localparam logic [3:0] OP_DISP    = 4'd8;
    localparam logic [3:0] OP_COMPL   = 4'd9;
    localparam logic [3:0] OP_WAKE    = 4'd10;
    localparam logic [3:0] OP_STSP    = 4'd11;
    localparam logic [3:0] OP_STATS   = 4'd12;

    localparam logic [2:0] S_OK      = 3'd0;
    localparam logic [2:0] S_NOINIT  = 3'd1;
    localparam logic [2:0] S_FULL    = 3'd2;
    localparam logic [2:0] S_NOTASK  = 3'd3;
    localparam logic [2:0] S_BADST   = 3'd4;
    localparam logic [2:0] S_NORUN   = 3'd5;

    localparam logic [1:0] ST_READY     = 2'd0;
    localparam logic [1:0] ST_RUNNING   = 2'd1;
    localparam logic [1:0] ST_BLOCKED   = 2'd2;
    localparam logic [1:0] ST_SUSPENDED = 2'd3;

    localparam logic [31:0] LOWEST_PRIO = 32'hFFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input beat, start command
        logic step;     // one scan / shift step
        logic finish;   // apply end-of-command updates, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan;     // command needs a scan
        logic last;     // scan at last element
    } t_stat;
endpackage

@@ design/pts_ctrl.sv @@
// Controller for the priority task scheduler: sequences load, scan, finish
// and output. Depends on pts_pkg.
module pts_ctrl
    import pts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [1:0] C_IDLE = 2'd0, C_DEC = 2'd1, C_SCAN = 2'd2, C_FIN = 2'd3;
    logic [1:0] r_st, n_st;
    logic r_ov, n_ov;

    always_comb begin
        n_st = r_st;
        n_ov = r_ov;
        o_cmd = '0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_st)
            C_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_st = C_DEC;
                end
            end
            C_DEC: n_st = i_stat.scan ? C_SCAN : C_FIN;
            C_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) n_st = C_FIN;
            end
            C_FIN: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ov = 1'b1;
                    n_st = C_IDLE;
                end
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    assign o_in_ready  = (r_st == C_IDLE);
    assign o_out_valid = r_ov;

    a_fin_only_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> r_st == C_FIN) else $error("finish outside FIN");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_st == C_DEC) else $error("load did not decode");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> r_ov) else $error("result lost");
endmodule

@@ design/pts_dp.sv @@
// Datapath for the priority task scheduler: task table, counters, one-entry
// per cycle scan for wake/dispatch/delete, result register. Depends on pts_pkg.
module pts_dp
    import pts_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic [3:0]  i_opcode,
    input  logic [3:0]  i_entry_sel,
    input  logic [31:0] i_prio,
    input  logic [31:0] i_period,
    input  logic [31:0] i_delay,
    input  logic [31:0] i_now,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [2:0]  o_status,
    output logic [3:0]  o_res_idx,
    output logic        o_disp,
    output logic [31:0] o_runs,
    output logic [31:0] o_sw,
    output logic [31:0] o_idl
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [31:0] r_pri [MAX_ENTRIES];
    logic [31:0] r_per [MAX_ENTRIES];
    logic [31:0] r_wake[MAX_ENTRIES];
    logic [31:0] r_runs[MAX_ENTRIES];
    logic [1:0]  r_est [MAX_ENTRIES];
    logic        r_idle[MAX_ENTRIES];

    logic [CW-1:0] r_used;
    logic [IW-1:0] r_run;
    logic r_rdy, r_sch;
    logic [31:0] r_dtime, r_swc, r_idc;
    logic [4:0] r_lim;

    logic [3:0]  r_op, r_tix;
    logic [31:0] r_prio, r_perq, r_dly, r_now;
    logic [CW-1:0] r_i;        // scan pointer
    logic r_found;
    logic [IW-1:0] r_best;
    logic [31:0] r_bestp;

    logic [CW-1:0] lim_eff;
    assign lim_eff = (32'(r_lim) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(r_lim);

    logic valid_ix, run_ok, gate, needs_scan, busy;
    logic [IW-1:0] tix, ii;
    assign tix = IW'(r_tix);
    assign valid_ix = (32'(r_tix) < 32'(r_used)) && (32'(r_tix) < MAX_ENTRIES);
    assign run_ok = CW'(r_run) < r_used;
    assign gate = !r_rdy && r_op != OP_INIT && r_op <= OP_STATS &&
                  !(r_op == OP_STSP && !r_tix[0]);
    assign busy = run_ok && r_est[r_run] == ST_RUNNING;
    assign needs_scan = !gate && ((r_op == OP_WAKE) ||
        (r_op == OP_DISP && r_sch && !busy) ||
        (r_op == OP_DELETE && valid_ix && CW'(r_tix) + 1'b1 != r_used));
    assign ii = r_i[IW-1:0];

    // scan runs pointer from start to used-1 (delete: to used-2)
    logic [CW-1:0] scan_end;
    assign scan_end = (r_op == OP_DELETE) ? r_used - CW'(2) : r_used - CW'(1);
    assign o_stat.scan = needs_scan && r_used != '0;
    assign o_stat.last = (r_i >= scan_end);

    logic exp_i;
    assign exp_i = r_est[ii] == ST_BLOCKED && r_now >= r_wake[ii];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= 5'd16;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_data;
        end
    end

    // captured command and dispatch candidate tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode; r_tix <= i_entry_sel; r_prio <= i_prio;
            r_perq <= i_period; r_dly <= i_delay; r_now <= i_now;
            r_i <= (i_opcode == OP_DELETE) ? CW'(i_entry_sel) : '0;
            r_found <= 1'b0;
            r_best <= '0;
            r_bestp <= '0;
        end else if (i_cmd.step) begin
            r_i <= r_i + 1'b1;
            if (r_op == OP_DISP && (r_est[ii] == ST_READY || exp_i) &&
                (!r_found || r_pri[ii] < r_bestp)) begin
                r_found <= 1'b1; r_best <= ii; r_bestp <= r_pri[ii];
            end
        end
    end

    // table: scan/shift steps, then per-opcode updates and result at finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_run <= '0; r_rdy <= 1'b0; r_sch <= 1'b0;
            r_dtime <= '0; r_swc <= '0; r_idc <= '0;
        end else if (i_cmd.step) begin
            if (r_op == OP_DELETE) begin
                r_pri[ii] <= r_pri[ii+1'b1]; r_per[ii] <= r_per[ii+1'b1];
                r_wake[ii] <= r_wake[ii+1'b1]; r_runs[ii] <= r_runs[ii+1'b1];
                r_est[ii] <= r_est[ii+1'b1]; r_idle[ii] <= r_idle[ii+1'b1];
            end else if (exp_i) begin
                r_est[ii] <= ST_READY;
            end
        end else if (i_cmd.finish) begin
            o_status <= S_OK; o_res_idx <= '0; o_disp <= 1'b0;
            o_runs <= '0; o_sw <= '0; o_idl <= '0;
            if (gate) begin
                o_status <= S_NOINIT;
            end else begin
                case (r_op)
                    OP_INIT: begin
                        if (lim_eff == '0) o_status <= S_FULL;
                        else begin
                            r_used <= CW'(1); r_run <= '0; r_swc <= '0; r_idc <= '0;
                            r_dtime <= '0; r_sch <= 1'b0; r_rdy <= 1'b1;
                            r_pri[0] <= LOWEST_PRIO; r_per[0] <= '0; r_wake[0] <= r_now;
                            r_runs[0] <= '0; r_est[0] <= ST_READY; r_idle[0] <= 1'b1;
                        end
                    end
                    OP_CREATE: begin
                        if (r_used >= lim_eff) o_status <= S_FULL;
                        else begin
                            r_pri[IW'(r_used)] <= r_prio; r_per[IW'(r_used)] <= r_perq;
                            r_wake[IW'(r_used)] <= r_now; r_runs[IW'(r_used)] <= '0;
                            r_est[IW'(r_used)] <= ST_READY; r_idle[IW'(r_used)] <= 1'b0;
                            o_res_idx <= 4'(r_used);
                            r_used <= r_used + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (!valid_ix) o_status <= S_NOTASK;
                        else begin
                            if (CW'(r_tix) + 1'b1 != r_used && r_run > tix)
                                r_run <= r_run - 1'b1;
                            r_used <= r_used - 1'b1;
                        end
                    end
                    OP_SUSPEND: begin
                        if (!valid_ix) o_status <= S_NOTASK;
                        else r_est[tix] <= ST_SUSPENDED;
                    end
                    OP_RESUME: begin
                        if (!valid_ix) o_status <= S_NOTASK;
                        else if (r_est[tix] != ST_SUSPENDED) o_status <= S_BADST;
                        else begin
                            r_est[tix] <= ST_READY; r_wake[tix] <= r_now;
                        end
                    end
                    OP_SETPER: begin
                        if (!valid_ix) o_status <= S_NOTASK;
                        else r_per[tix] <= r_perq;
                    end
                    OP_SETPRI: begin
                        if (!valid_ix) o_status <= S_NOTASK;
                        else r_pri[tix] <= r_prio;
                    end
                    OP_DELAY: begin
                        if (!r_sch) o_status <= S_NORUN;
                        else if (!run_ok) o_status <= S_NOTASK;
                        else begin
                            r_est[r_run] <= ST_BLOCKED; r_wake[r_run] <= r_now + r_dly;
                        end
                    end
                    OP_DISP: begin
                        if (!r_sch) o_status <= S_NORUN;
                        else if (busy) o_status <= S_BADST;
                        else if (!r_found) o_status <= S_NORUN;
                        else begin
                            r_run <= r_best; r_est[r_best] <= ST_RUNNING;
                            r_runs[r_best] <= r_runs[r_best] + 1'b1;
                            r_swc <= r_swc + 1'b1;
                            if (r_idle[r_best]) r_idc <= r_idc + 1'b1;
                            r_dtime <= r_now;
                            o_res_idx <= 4'(r_best); o_disp <= 1'b1;
                        end
                    end
                    OP_COMPL: begin
                        if (!run_ok) o_status <= S_NOTASK;
                        else begin
                            o_res_idx <= 4'(r_run);
                            if (r_est[r_run] == ST_RUNNING) begin
                                if (r_per[r_run] != '0) begin
                                    r_wake[r_run] <= r_dtime + r_per[r_run];
                                    r_est[r_run] <= ST_BLOCKED;
                                end else r_est[r_run] <= ST_READY;
                            end
                        end
                    end
                    OP_STSP: r_sch <= r_tix[0];
                    OP_STATS: begin
                        o_sw <= r_swc; o_idl <= r_idc;
                        if (!valid_ix) o_status <= S_NOTASK;
                        else o_runs <= r_runs[tix];
                    end
                    default: ;
                endcase
            end
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_ENTRIES)) else $error("table overflow");
    a_disp_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_op == OP_DISP && r_sch && !busy && !gate && r_found)
        |=> o_disp) else $error("dispatch lost");
    a_rdy_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_rdy) |-> r_rdy) else $error("ready flag dropped");
endmodule

@@ design/priority_task_scheduler.sv @@
// Top level of the priority task scheduler: channels, config register and
// wiring of pts_ctrl and pts_dp. Depends on pts_pkg.
//
// Usage: one command beat on the slave stream, one result beat on the master
// stream. s_axis_tuser carries the opcode; s_axis_tdata carries entry_sel,
// priority_req, period, delay_ticks and now from bit 0 up, zero padded.
// m_axis_tdata = status_code, result_index, dispatched, task_runs,
// switch_total, idle_total from bit 0 up.
// Sequence: the accepted beat is captured, decoded in DEC and, for wake,
// dispatch and delete, scanned in SCAN over every used entry (delete: each
// entry shifted, up to MAX_ENTRIES-1) by the single-entry-per-cycle scan in
// the datapath; FIN then loads the output register behind m_axis_tvalid.
// One command at a time: the next is accepted only back in idle.
// A result waits in the output register while the sink stalls; the next
// command is accepted and decoded meanwhile and finishes once the register
// is free. The user writes task_limit through i_cfg_we/i_cfg_data only
// while idle; the block itself does not enforce this.
// Reset (synchronous, active low) empties the table, clears the counters,
// stops scheduling, marks the block uninitialized and sets task_limit to 16.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [3:0]   s_axis_tuser,  // opcode
    input  logic [135:0] s_axis_tdata,  // entry_sel, priority_req, period,
                                        // delay_ticks, now
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata   // status_code, result_index, dispatched,
                                        // task_runs, switch_total, idle_total
);
    t_cmd  cmd;
    t_stat stat;
    logic [2:0]  status;
    logic [3:0]  ridx;
    logic        disp;
    logic [31:0] runs, sw, idl;

    pts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_stat(stat), .o_cmd(cmd)
    );

    pts_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_opcode(s_axis_tuser), .i_entry_sel(s_axis_tdata[3:0]),
        .i_prio(s_axis_tdata[35:4]), .i_period(s_axis_tdata[67:36]),
        .i_delay(s_axis_tdata[99:68]), .i_now(s_axis_tdata[131:100]),
        .i_cmd(cmd), .o_stat(stat),
        .o_status(status), .o_res_idx(ridx), .o_disp(disp),
        .o_runs(runs), .o_sw(sw), .o_idl(idl)
    );

    assign m_axis_tdata = {idl, sw, runs, disp, ridx, status};
endmodule

@@ tb/tb_priority_task_scheduler.sv @@
// Testbench for priority_task_scheduler: random and directed command beats,
// checked against a behavioral task-table predictor. Depends on pts_pkg and the RTL.
`timescale 1ns / 100ps

class sched_scoreboard;
    // predictor state
    logic [31:0] prio_q [16];
    logic [31:0] per_q [16];
    logic [31:0] wake_q [16];
    logic [31:0] runs_q [16];
    logic [1:0]  st_q [16];
    logic        idle_q [16];
    int unsigned used;
    int unsigned run_idx;
    bit          inited;
    bit          sched_on;
    logic [31:0] disp_time;
    logic [31:0] sw_cnt;
    logic [31:0] idle_cnt;
    int unsigned limit;
    logic [103:0] expected_q [$];
    int          errors;

    function new();
        used = 0; run_idx = 0; inited = 0; sched_on = 0;
        disp_time = 0; sw_cnt = 0; idle_cnt = 0; limit = 16; errors = 0;
    endfunction

    function int unsigned eff_limit();
        return (limit > 16) ? 16 : limit;
    endfunction

    function void wake_all(logic [31:0] now);
        for (int i = 0; i < used; i++)
            if (st_q[i] == pts_pkg::ST_BLOCKED && now >= wake_q[i])
                st_q[i] = pts_pkg::ST_READY;
    endfunction

    function void put(int i, logic [31:0] p, logic [31:0] per, logic [31:0] now, bit idl);
        prio_q[i] = p; per_q[i] = per; wake_q[i] = now; runs_q[i] = 0;
        st_q[i] = pts_pkg::ST_READY; idle_q[i] = idl;
    endfunction

    // Note an accepted command beat and queue its result.
    function void note_command(logic [3:0] op, logic [135:0] d);
        logic [3:0]  idx;
        logic [31:0] p, per, dly, now;
        logic [2:0]  status;
        logic [3:0]  ridx;
        bit          disp, found, ok;
        logic [31:0] runs, sw, idl, bestp;
        int unsigned best;
        idx = d[3:0]; p = d[35:4]; per = d[67:36];
        dly = d[99:68]; now = d[131:100];
        status = pts_pkg::S_OK; ridx = 0; disp = 0; runs = 0; sw = 0; idl = 0;
        ok = idx < used;
        found = 0; best = 0; bestp = 0;
        if (!inited && op != pts_pkg::OP_INIT && op <= pts_pkg::OP_STATS
            && !(op == pts_pkg::OP_STSP && !idx[0])) begin
            status = pts_pkg::S_NOINIT;
        end else begin
            case (op)
                pts_pkg::OP_INIT: begin
                    if (eff_limit() == 0) status = pts_pkg::S_FULL;
                    else begin
                        used = 1; run_idx = 0; sw_cnt = 0; idle_cnt = 0; disp_time = 0;
                        sched_on = 0; inited = 1;
                        put(0, pts_pkg::LOWEST_PRIO, 0, now, 1);
                    end
                end
                pts_pkg::OP_CREATE: begin
                    if (used >= eff_limit()) status = pts_pkg::S_FULL;
                    else begin
                        put(int'(used), p, per, now, 0);
                        ridx = 4'(used);
                        used++;
                    end
                end
                pts_pkg::OP_DELETE: begin
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else begin
                        if (idx + 1 != used) begin
                            for (int i = idx; i + 1 < used; i++) begin
                                prio_q[i] = prio_q[i+1]; per_q[i] = per_q[i+1];
                                wake_q[i] = wake_q[i+1]; runs_q[i] = runs_q[i+1];
                                st_q[i] = st_q[i+1]; idle_q[i] = idle_q[i+1];
                            end
                            if (run_idx > idx) run_idx--;
                        end
                        used--;
                    end
                end
                pts_pkg::OP_SUSPEND: begin
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else st_q[idx] = pts_pkg::ST_SUSPENDED;
                end
                pts_pkg::OP_RESUME: begin
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else if (st_q[idx] != pts_pkg::ST_SUSPENDED) status = pts_pkg::S_BADST;
                    else begin
                        st_q[idx] = pts_pkg::ST_READY;
                        wake_q[idx] = now;
                    end
                end
                pts_pkg::OP_SETPER: begin
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else per_q[idx] = per;
                end
                pts_pkg::OP_SETPRI: begin
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else prio_q[idx] = p;
                end
                pts_pkg::OP_DELAY: begin
                    if (!sched_on) status = pts_pkg::S_NORUN;
                    else if (run_idx >= used) status = pts_pkg::S_NOTASK;
                    else begin
                        st_q[run_idx] = pts_pkg::ST_BLOCKED;
                        wake_q[run_idx] = now + dly;
                    end
                end
                pts_pkg::OP_DISP: begin
                    if (!sched_on) status = pts_pkg::S_NORUN;
                    else if (run_idx < used && st_q[run_idx] == pts_pkg::ST_RUNNING)
                        status = pts_pkg::S_BADST;
                    else begin
                        wake_all(now);
                        for (int i = 0; i < used; i++)
                            if (st_q[i] == pts_pkg::ST_READY && (!found || prio_q[i] < bestp))
                            begin
                                found = 1; best = i; bestp = prio_q[i];
                            end
                        if (!found) status = pts_pkg::S_NORUN;
                        else begin
                            run_idx = best;
                            st_q[best] = pts_pkg::ST_RUNNING;
                            runs_q[best]++;
                            sw_cnt++;
                            if (idle_q[best]) idle_cnt++;
                            disp_time = now;
                            ridx = 4'(best);
                            disp = 1;
                        end
                    end
                end
                pts_pkg::OP_COMPL: begin
                    if (run_idx >= used) status = pts_pkg::S_NOTASK;
                    else begin
                        ridx = 4'(run_idx);
                        if (st_q[run_idx] == pts_pkg::ST_RUNNING) begin
                            if (per_q[run_idx] > 0) begin
                                wake_q[run_idx] = disp_time + per_q[run_idx];
                                st_q[run_idx] = pts_pkg::ST_BLOCKED;
                            end else st_q[run_idx] = pts_pkg::ST_READY;
                        end
                    end
                end
                pts_pkg::OP_WAKE: wake_all(now);
                pts_pkg::OP_STSP: sched_on = idx[0];
                pts_pkg::OP_STATS: begin
                    sw = sw_cnt; idl = idle_cnt;
                    if (!ok) status = pts_pkg::S_NOTASK;
                    else runs = runs_q[idx];
                end
                default: ;
            endcase
        end
        expected_q.push_back({idl, sw, runs, disp, ridx, status});
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(logic [103:0] got);
        logic [103:0] exp_v;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_v = expected_q.pop_front();
        if (got[2:0] !== exp_v[2:0])
            $display("%0t: status exp %0d got %0d", $time, exp_v[2:0], got[2:0]);
        if (got[6:3] !== exp_v[6:3])
            $display("%0t: index exp %0d got %0d", $time, exp_v[6:3], got[6:3]);
        if (got[7] !== exp_v[7])
            $display("%0t: dispatched exp %0d got %0d", $time, exp_v[7], got[7]);
        if (got[39:8] !== exp_v[39:8])
            $display("%0t: runs exp %h got %h", $time, exp_v[39:8], got[39:8]);
        if (got[71:40] !== exp_v[71:40])
            $display("%0t: switches exp %h got %h", $time, exp_v[71:40], got[71:40]);
        if (got[103:72] !== exp_v[103:72])
            $display("%0t: idle exp %h got %h", $time, exp_v[103:72], got[103:72]);
        if (got !== exp_v) errors++;
    endfunction
endclass

module tb_priority_task_scheduler;
    import pts_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [4:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [3:0]   s_axis_tuser = '0;    // opcode
    logic [135:0] s_axis_tdata = '0;   // entry_sel, priority_req, period,
                                        // delay_ticks, now
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;        // status_code, result_index, dispatched,
                                        // task_runs, switch_total, idle_total

    int           send_idle_pct = 0;    // percent of cycles the sender holds off
    int           recv_idle_pct = 0;    // percent of cycles the sink stalls
    logic [31:0]  tick = 0;             // running time base fed in "now"
    sched_scoreboard sb;

    always #5 i_clk = ~i_clk;

    priority_task_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Sink side: random stall, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one command beat; held until accepted. Starts at a falling edge once the random hold-off ends.
    task automatic send_cmd(input logic [3:0] op, input logic [3:0] idx,
                            input logic [31:0] p, input logic [31:0] per,
                            input logic [31:0] dly, input logic [31:0] now);
        do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, now, dly, per, p, idx};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, {4'b0, now, dly, per, p, idx});
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every queued result is back, plus slack for scan latency.
    task automatic drain();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (MaxEntriesDef + 8) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [4:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    // Mostly a well-formed scheduling mix: create, dispatch, complete, delay.
    task automatic random_cmd();
        logic [3:0] op;
        int unsigned r;
        r = $urandom_range(99);
        tick = tick + $urandom_range(6);
        if (r < 3)       op = OP_INIT;
        else if (r < 14) op = OP_CREATE;
        else if (r < 19) op = OP_DELETE;
        else if (r < 24) op = OP_SUSPEND;
        else if (r < 29) op = OP_RESUME;
        else if (r < 32) op = OP_SETPER;
        else if (r < 35) op = OP_SETPRI;
        else if (r < 41) op = OP_DELAY;
        else if (r < 63) op = OP_DISP;
        else if (r < 80) op = OP_COMPL;
        else if (r < 84) op = OP_WAKE;
        else if (r < 88) op = OP_STSP;
        else if (r < 96) op = OP_STATS;
        else             op = 4'($urandom_range(15));
        send_cmd(op,
                 (op == OP_STSP && $urandom_range(3) != 0) ? 4'd1
                     : 4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                   : $urandom_range(sb.used)),
                 ($urandom_range(3) == 0) ? rnd32() : $urandom_range(7),
                 ($urandom_range(2) == 0) ? 32'h0 : ($urandom_range(3) == 0 ? rnd32()
                                                      : $urandom_range(20)),
                 ($urandom_range(4) == 0) ? rnd32() : $urandom_range(15),
                 ($urandom_range(30) == 0) ? rnd32() : tick);
    endtask

    initial begin
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: uninitialized access, stop before init, limits, corner codes
        send_cmd(OP_CREATE, 0, 0, 0, 0, 0);
        send_cmd(OP_STSP, 0, 0, 0, 0, 0);
        send_cmd(OP_STSP, 1, 0, 0, 0, 0);
        send_cmd(4'd15, 4'hF, '1, '1, '1, '1);
        set_limit(5'd0);
        send_cmd(OP_INIT, 0, 0, 0, 0, 5);
        set_limit(5'd31);
        send_cmd(OP_INIT, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_cmd(OP_DISP, 0, 0, 0, 0, 10);
        send_cmd(OP_DELAY, 0, 0, 0, 3, 10);
        send_cmd(OP_STSP, 1, 0, 0, 0, 10);
        send_cmd(OP_CREATE, 0, 32'h0, 32'd5, 0, 10);
        send_cmd(OP_CREATE, 0, 32'hFFFF_FFFF, 32'h0, 0, 10);
        send_cmd(OP_CREATE, 0, 32'd0, 32'hFFFF_FFFF, 0, 10);
        send_cmd(OP_DISP, 0, 0, 0, 0, 11);
        send_cmd(OP_DISP, 0, 0, 0, 0, 11);
        send_cmd(OP_COMPL, 0, 0, 0, 0, 12);
        send_cmd(OP_DISP, 0, 0, 0, 0, 12);
        send_cmd(OP_DELAY, 0, 0, 0, 32'hFFFF_FFFF, 12);
        send_cmd(OP_COMPL, 0, 0, 0, 0, 13);
        send_cmd(OP_RESUME, 1, 0, 0, 0, 13);
        send_cmd(OP_SUSPEND, 15, 0, 0, 0, 13);
        send_cmd(OP_SETPRI, 2, 32'd9, 0, 0, 13);
        send_cmd(OP_SETPER, 2, 0, 32'd0, 0, 13);
        send_cmd(OP_DELETE, 1, 0, 0, 0, 13);
        send_cmd(OP_WAKE, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_cmd(OP_STATS, 0, 0, 0, 0, 13);
        send_cmd(OP_STATS, 14, 0, 0, 0, 13);

        set_limit(5'd1);
        send_idle_pct = 31; recv_idle_pct = 53;
        for (int i = 0; i < 220; i++) begin
            if (i == 40) set_limit(5'd4);
            if (i == 120) set_limit(5'd16);
            random_cmd();
        end
        drain();
        send_idle_pct = 53; recv_idle_pct = 31;
        set_limit(5'd6);
        for (int i = 0; i < 215; i++) random_cmd();
        set_limit(5'd16);
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 215; i++) random_cmd();

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("priority_task_scheduler: match");
        else
            $display("priority_task_scheduler: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("priority_task_scheduler: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_dp.sv
design/priority_task_scheduler.sv
tb/tb_priority_task_scheduler.sv
